/* rtl/core/pjts_pkg.sv */
// Package for the job table selector: word types, table entry type and codes.
// Used by pjts_table, policy_job_table_selector and pjts_port_checker.
package pjts_pkg;

    localparam int TABLE_DEPTH = 256;

    // input modes
    localparam logic [1:0] MODE_TICK     = 2'd0;
    localparam logic [1:0] MODE_INSERT   = 2'd1;
    localparam logic [1:0] MODE_DISPATCH = 2'd2;
    localparam logic [1:0] MODE_COMPLETE = 2'd3;

    // result status codes
    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_FULL     = 2'd1;
    localparam logic [1:0] STAT_NO_READY = 2'd2;
    localparam logic [1:0] STAT_NOT_RUN  = 2'd3;

    // selection policies
    localparam logic [1:0] POL_ARRIVAL  = 2'd0;
    localparam logic [1:0] POL_RUNTIME  = 2'd1;
    localparam logic [1:0] POL_PRIORITY = 2'd2;
    localparam logic [1:0] POL_NONE     = 2'd3;

    // entry states
    localparam logic [1:0] ENT_WAITING = 2'd0;
    localparam logic [1:0] ENT_RUNNING = 2'd1;
    localparam logic [1:0] ENT_DONE    = 2'd2;

    localparam logic [15:0] TIME_MAX  = 16'hFFFF;
    localparam logic [8:0]  COUNT_MAX = 9'h1FF;

    typedef struct packed {
        logic [1:0]  mode;
        logic [15:0] job_id;
        logic [15:0] arrive_at;
        logic [15:0] runtime;
        logic [7:0]  priority_req;
        logic [7:0]  slot;
    } in_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] out_job_id;
        logic [7:0]  out_slot;
        logic [15:0] start_at;
        logic [16:0] finish_at;
        logic [8:0]  done_count;
        logic [15:0] now;
    } out_t;

    typedef struct packed {
        logic [1:0]  state;
        logic [15:0] id;
        logic [15:0] arrival;
        logic [15:0] runtime;
        logic [7:0]  prio;
        logic [15:0] start;
    } entry_t;

    // ordering key of an entry under a policy
    function automatic logic [15:0] sel_key(logic [1:0] pol, entry_t e);
        logic [15:0] k;
        unique case (pol)
            POL_ARRIVAL: k = e.arrival;
            POL_RUNTIME: k = e.runtime;
            default:     k = {8'h00, e.prio};
        endcase
        return k;
    endfunction

endpackage

/* rtl/core/pjts_table.sv */
// Job table memory: one write port, one read port with registered read data.
// Depends on pjts_pkg for the entry type.
module pjts_table #(
    parameter int DEPTH = pjts_pkg::TABLE_DEPTH,
    parameter int IDX_W = $clog2(DEPTH)
) (
    input  logic                 clk,
    input  logic                 wr_en,
    input  logic [IDX_W-1:0]     wr_addr,
    input  pjts_pkg::entry_t     wr_data,
    input  logic                 rd_en,
    input  logic [IDX_W-1:0]     rd_addr,
    output pjts_pkg::entry_t     rd_data
);

    pjts_pkg::entry_t mem [DEPTH];
    pjts_pkg::entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/core/policy_job_table_selector.sv */
// Job table selector top level: control FSM, counters and output register.
// Depends on pjts_pkg and pjts_table.
//
// A tick, an insert, a dispatch on an empty table and a completion of a slot at
// or past job_count go straight to the result state; a completion of a stored
// slot first does one table read, and a dispatch on a filled table scans
// job_count entries: the scan reads one table entry per cycle through the
// single read port of the table memory. One word is in work at a time; the
// next input word is taken as soon as the previous result sits in the output
// register, even if it has not yet been taken, and a result that finds the
// output register still occupied holds the block until it is taken. Ties in a
// dispatch go to the lowest slot; policy 3 picks the lowest ready slot. The
// time counter and completed count saturate.
module policy_job_table_selector #(
    parameter int TABLE_DEPTH = pjts_pkg::TABLE_DEPTH
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_we,
    input  logic [1:0]      cfg_wdata,
    input  logic            in_valid,
    output logic            in_ready,
    input  pjts_pkg::in_t   in_data,
    output logic            out_valid,
    input  logic            out_ready,
    output pjts_pkg::out_t  out_data
);

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int SW    = (CNT_W > 8) ? CNT_W : 8;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SCAN   = 4'b0010,
        S_CHECK  = 4'b0100,
        S_RESULT = 4'b1000
    } state_t;

    state_t             state_reg, state_next;
    logic [1:0]         policy_reg, policy_next;
    logic [CNT_W-1:0]   job_count_reg, job_count_next;
    logic [15:0]        time_reg, time_next;
    logic [8:0]         completed_reg, completed_next;
    logic [7:0]         slot_reg, slot_next;
    logic [IDX_W-1:0]   scan_addr_reg, scan_addr_next;
    logic               found_reg, found_next;
    logic [IDX_W-1:0]   best_idx_reg, best_idx_next;
    pjts_pkg::entry_t   best_reg, best_next;
    pjts_pkg::out_t     res_reg, res_next;
    logic               out_valid_reg, out_valid_next;
    pjts_pkg::out_t     out_reg, out_next;

    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    pjts_pkg::entry_t   wr_data;
    logic               rd_en;
    logic [IDX_W-1:0]   rd_addr;
    pjts_pkg::entry_t   rd_data;

    logic [SW-1:0]      slot_ext;
    logic [SW-1:0]      cnt_ext;
    logic               eligible;
    logic               take;
    logic               scan_last;
    pjts_pkg::entry_t   upd;

    pjts_table #(
        .DEPTH (TABLE_DEPTH),
        .IDX_W (IDX_W)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    assign slot_ext  = SW'(in_data.slot);
    assign cnt_ext   = SW'(job_count_reg);
    assign eligible  = (rd_data.state == pjts_pkg::ENT_WAITING) &&
                       (rd_data.arrival <= time_reg);
    assign take      = eligible &&
                       (!found_reg ||
                        ((policy_reg != pjts_pkg::POL_NONE) &&
                         (pjts_pkg::sel_key(policy_reg, rd_data) <
                          pjts_pkg::sel_key(policy_reg, best_reg))));
    assign scan_last = (CNT_W'(scan_addr_reg) == (job_count_reg - 1'b1));

    always_comb
    begin
        state_next     = state_reg;
        policy_next    = cfg_we ? cfg_wdata : policy_reg;
        job_count_next = job_count_reg;
        time_next      = time_reg;
        completed_next = completed_reg;
        slot_next      = slot_reg;
        scan_addr_next = scan_addr_reg;
        found_next     = found_reg;
        best_idx_next  = best_idx_reg;
        best_next      = best_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_next       = out_reg;
        wr_en          = 1'b0;
        wr_addr        = '0;
        wr_data        = '0;
        rd_en          = 1'b0;
        rd_addr        = '0;
        upd            = rd_data;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    res_next            = '0;
                    res_next.done_count = completed_reg;
                    res_next.now        = time_reg;
                    slot_next           = in_data.slot;
                    state_next          = S_RESULT;
                    unique case (in_data.mode)
                        pjts_pkg::MODE_TICK:
                        begin
                            if (time_reg != pjts_pkg::TIME_MAX)
                            begin
                                time_next = time_reg + 16'd1;
                            end
                            res_next.now = time_next;
                        end
                        pjts_pkg::MODE_INSERT:
                        begin
                            if (job_count_reg >= CNT_W'(TABLE_DEPTH))
                            begin
                                res_next.status = pjts_pkg::STAT_FULL;
                            end
                            else
                            begin
                                wr_en           = 1'b1;
                                wr_addr         = IDX_W'(job_count_reg);
                                wr_data.state   = pjts_pkg::ENT_WAITING;
                                wr_data.id      = in_data.job_id;
                                wr_data.arrival = in_data.arrive_at;
                                wr_data.runtime = in_data.runtime;
                                wr_data.prio    = in_data.priority_req;
                                wr_data.start   = '0;
                                job_count_next  = job_count_reg + 1'b1;
                                res_next.out_job_id = in_data.job_id;
                                res_next.out_slot   = 8'(job_count_reg);
                            end
                        end
                        pjts_pkg::MODE_DISPATCH:
                        begin
                            if (job_count_reg == '0)
                            begin
                                res_next.status = pjts_pkg::STAT_NO_READY;
                            end
                            else
                            begin
                                rd_en          = 1'b1;
                                rd_addr        = '0;
                                scan_addr_next = '0;
                                found_next     = 1'b0;
                                state_next     = S_SCAN;
                            end
                        end
                        default:
                        begin
                            if (slot_ext >= cnt_ext)
                            begin
                                res_next.status   = pjts_pkg::STAT_NOT_RUN;
                                res_next.out_slot = in_data.slot;
                            end
                            else
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = slot_ext[IDX_W-1:0];
                                state_next = S_CHECK;
                            end
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                // rd_data holds the entry at scan_addr_reg
                if (take)
                begin
                    found_next    = 1'b1;
                    best_idx_next = scan_addr_reg;
                    best_next     = rd_data;
                end
                if (scan_last)
                begin
                    state_next = S_RESULT;
                    if (found_next)
                    begin
                        upd       = best_next;
                        upd.state = pjts_pkg::ENT_RUNNING;
                        upd.start = time_reg;
                        wr_en     = 1'b1;
                        wr_addr   = best_idx_next;
                        wr_data   = upd;
                        res_next.out_job_id = best_next.id;
                        res_next.out_slot   = 8'(best_idx_next);
                        res_next.start_at   = time_reg;
                    end
                    else
                    begin
                        res_next.status = pjts_pkg::STAT_NO_READY;
                    end
                end
                else
                begin
                    rd_en          = 1'b1;
                    rd_addr        = scan_addr_reg + 1'b1;
                    scan_addr_next = scan_addr_reg + 1'b1;
                end
            end
            S_CHECK:
            begin
                state_next        = S_RESULT;
                res_next.out_slot = slot_reg;
                if (rd_data.state != pjts_pkg::ENT_RUNNING)
                begin
                    res_next.status = pjts_pkg::STAT_NOT_RUN;
                end
                else
                begin
                    upd.state = pjts_pkg::ENT_DONE;
                    wr_en     = 1'b1;
                    wr_addr   = IDX_W'(SW'(slot_reg));
                    wr_data   = upd;
                    if (completed_reg != pjts_pkg::COUNT_MAX)
                    begin
                        completed_next = completed_reg + 9'd1;
                    end
                    res_next.out_job_id = rd_data.id;
                    res_next.start_at   = rd_data.start;
                    res_next.finish_at  = {1'b0, rd_data.start} + {1'b0, rd_data.runtime};
                    res_next.done_count = completed_next;
                end
            end
            S_RESULT:
            begin
                // hold until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            policy_reg    <= pjts_pkg::POL_ARRIVAL;
            job_count_reg <= '0;
            time_reg      <= '0;
            completed_reg <= '0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            policy_reg    <= policy_next;
            job_count_reg <= job_count_next;
            time_reg      <= time_next;
            completed_reg <= completed_next;
            found_reg     <= found_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg      <= slot_next;
        scan_addr_reg <= scan_addr_next;
        best_idx_reg  <= best_idx_next;
        best_reg      <= best_next;
        res_reg       <= res_next;
        out_reg       <= out_next;
    end

endmodule

/* rtl/core/pjts_checker.sv */
// Port checker for the job table selector, bound to the top level.
// Depends on pjts_pkg for the word types and status codes.
module pjts_port_checker (
    input logic            clk,
    input logic            rst_n,
    input logic            in_valid,
    input logic            in_ready,
    input pjts_pkg::in_t   in_data,
    input logic            out_valid,
    input logic            out_ready,
    input pjts_pkg::out_t  out_data
);

    // stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result word changed while stalled");

    // pending input word holds
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(in_data))
        else $error("input word changed while stalled");

    // one word in work at a time
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken while a word is in work");

    // finish time only on a good completion, never before start
    a_finish: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.finish_at != 17'd0) |->
            (out_data.status == pjts_pkg::STAT_OK) &&
            (out_data.finish_at >= {1'b0, out_data.start_at}))
        else $error("finish time on a bad result");

endmodule

bind policy_job_table_selector pjts_port_checker u_pjts_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

/* verif/pjts_checker.sv */
// Scoreboard for the job table selector: watches the config port and both word channels,
// predicts each result word from its own copy of the job table and compares them in order.
// Depends on pjts_pkg for the word types and the mode, status, policy and entry codes.
module pjts_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [1:0]                       cfg_wdata,
    input  logic                             in_valid,
    input  logic                             in_ready,
    input  pjts_pkg::in_t                    in_data,
    input  logic                             out_valid,
    input  logic                             out_ready,
    input  pjts_pkg::out_t                   out_data,
    output int                               fail_count,
    output int                               pending_count,
    output logic [pjts_pkg::TABLE_DEPTH-1:0] running_map,
    output logic [15:0]                      clock_now
);
    timeunit 1ns;
    timeprecision 1ps;

    pjts_pkg::entry_t                 job_table [pjts_pkg::TABLE_DEPTH];
    int                               jobs_stored = 0;
    logic [15:0]                      time_count = '0;
    logic [8:0]                       jobs_finished = '0;
    logic [1:0]                       sel_policy = pjts_pkg::POL_ARRIVAL;
    logic [pjts_pkg::TABLE_DEPTH-1:0] busy_slots = '0;
    pjts_pkg::out_t                   expected_words [$];
    int                               words_waiting = 0;
    int                               mismatches = 0;

    assign fail_count    = mismatches;
    assign pending_count = words_waiting;
    assign running_map   = busy_slots;
    assign clock_now     = time_count;

    // Apply one accepted word to the job table copy and return its result word.
    function automatic pjts_pkg::out_t predict_word(input pjts_pkg::in_t w);
        pjts_pkg::out_t r;
        int   best;
        int   s;
        logic wins;
        r    = '0;
        best = -1;
        case (w.mode)
            pjts_pkg::MODE_TICK:
                if (time_count != pjts_pkg::TIME_MAX)
                    time_count++;
            pjts_pkg::MODE_INSERT:
                if (jobs_stored >= pjts_pkg::TABLE_DEPTH)
                    r.status = pjts_pkg::STAT_FULL;
                else
                begin
                    job_table[jobs_stored] = '{pjts_pkg::ENT_WAITING, w.job_id, w.arrive_at,
                                               w.runtime, w.priority_req, 16'd0};
                    r.out_job_id = w.job_id;
                    r.out_slot   = 8'(jobs_stored);
                    jobs_stored++;
                end
            pjts_pkg::MODE_DISPATCH:
            begin
                // strict compare keeps the lowest slot on ties
                for (int i = 0; i < jobs_stored; i++)
                begin
                    if (job_table[i].state == pjts_pkg::ENT_WAITING &&
                        job_table[i].arrival <= time_count)
                    begin
                        wins = (best < 0);
                        if (!wins)
                        begin
                            case (sel_policy)
                                pjts_pkg::POL_ARRIVAL:
                                    wins = job_table[i].arrival < job_table[best].arrival;
                                pjts_pkg::POL_RUNTIME:
                                    wins = job_table[i].runtime < job_table[best].runtime;
                                pjts_pkg::POL_PRIORITY:
                                    wins = job_table[i].prio < job_table[best].prio;
                                default:
                                    wins = 1'b0;
                            endcase
                        end
                        if (wins)
                            best = i;
                    end
                end
                if (best < 0)
                    r.status = pjts_pkg::STAT_NO_READY;
                else
                begin
                    job_table[best].state = pjts_pkg::ENT_RUNNING;
                    job_table[best].start = time_count;
                    busy_slots[best]      = 1'b1;
                    r.out_job_id          = job_table[best].id;
                    r.out_slot            = 8'(best);
                    r.start_at            = time_count;
                end
            end
            default:
            begin
                s = int'(w.slot);
                if (s >= jobs_stored || job_table[s].state != pjts_pkg::ENT_RUNNING)
                begin
                    r.status   = pjts_pkg::STAT_NOT_RUN;
                    r.out_slot = w.slot;
                end
                else
                begin
                    job_table[s].state = pjts_pkg::ENT_DONE;
                    busy_slots[s]      = 1'b0;
                    if (jobs_finished != pjts_pkg::COUNT_MAX)
                        jobs_finished++;
                    r.out_job_id = job_table[s].id;
                    r.out_slot   = w.slot;
                    r.start_at   = job_table[s].start;
                    r.finish_at  = 17'(job_table[s].start) + 17'(job_table[s].runtime);
                end
            end
        endcase
        r.done_count = jobs_finished;
        r.now        = time_count;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want_v,
                               input logic [31:0] got_v);
        if (got_v !== want_v)
        begin
            $error("%s: expected %0d, got %0d", name, want_v, got_v);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin : monitor
        pjts_pkg::out_t want;
        if (rst_n)
        begin
            if (cfg_we)
                sel_policy = cfg_wdata;
            // retire the oldest expectation before queueing the word taken at this edge
            if (out_valid && out_ready)
            begin
                if (expected_words.size() == 0)
                begin
                    $error("result word with nothing expected: %p", out_data);
                    mismatches++;
                end
                else
                begin
                    want = expected_words.pop_front();
                    check_field("status", 32'(want.status), 32'(out_data.status));
                    check_field("out_job_id", 32'(want.out_job_id),
                                32'(out_data.out_job_id));
                    check_field("out_slot", 32'(want.out_slot), 32'(out_data.out_slot));
                    check_field("start_at", 32'(want.start_at), 32'(out_data.start_at));
                    check_field("finish_at", 32'(want.finish_at), 32'(out_data.finish_at));
                    check_field("done_count", 32'(want.done_count),
                                32'(out_data.done_count));
                    check_field("now", 32'(want.now), 32'(out_data.now));
                end
            end
            if (in_valid && in_ready)
                expected_words.push_back(predict_word(in_data));
            words_waiting = expected_words.size();
        end
    end

endmodule

/* verif/policy_job_table_selector_tb.sv */
// Testbench top for policy_job_table_selector: clock, reset, config writes, word stimulus
// with bursts and gaps, receiver stalls, and the verdict. Checking lives in pjts_checker.
// Depends on pjts_pkg, pjts_checker and the block's RTL.
module policy_job_table_selector_tb;
    timeunit 1ns;
    timeprecision 1ps;

    logic                             clk = 1'b0;
    logic                             rst_n;
    logic                             cfg_we;
    logic [1:0]                       cfg_wdata;
    logic                             in_valid;
    logic                             in_ready;
    pjts_pkg::in_t                    in_data;
    logic                             out_valid;
    logic                             out_ready;
    pjts_pkg::out_t                   out_data;
    int                               fail_count;
    int                               pending_count;
    logic [pjts_pkg::TABLE_DEPTH-1:0] running_map;
    logic [15:0]                      clock_now;
    bit                               hold_req = 1'b0;
    int                               inserts_sent = 0;

    policy_job_table_selector dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    pjts_checker chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .in_data       (in_data),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_data      (out_data),
        .fail_count    (fail_count),
        .pending_count (pending_count),
        .running_map   (running_map),
        .clock_now     (clock_now)
    );

    always #10 clk = ~clk;

    function automatic pjts_pkg::in_t job_word(input logic [1:0] mode, input logic [15:0] id,
                                               input logic [15:0] arrival,
                                               input logic [15:0] runtime,
                                               input logic [7:0] prio, input logic [7:0] slot);
        pjts_pkg::in_t w;
        w.mode         = mode;
        w.job_id       = id;
        w.arrive_at    = arrival;
        w.runtime      = runtime;
        w.priority_req = prio;
        w.slot         = slot;
        return w;
    endfunction

    // Random word; arrivals cluster around the current time and keys repeat often
    // so that eligibility edges and ties come up.
    function automatic pjts_pkg::in_t random_word();
        pjts_pkg::in_t w;
        int   pick;
        int   near;
        int   first;
        logic found;
        w = job_word(pjts_pkg::MODE_TICK, 16'($urandom), 16'($urandom), 16'($urandom),
                     8'($urandom), 8'($urandom));
        pick = $urandom_range(0, 99);
        if (pick < 28)
            w.mode = pjts_pkg::MODE_TICK;
        else if (pick < 52)
        begin
            w.mode = pjts_pkg::MODE_INSERT;
            case ($urandom_range(0, 9))
                0:       w.arrive_at = 16'd0;
                1:       w.arrive_at = pjts_pkg::TIME_MAX;
                2:       w.arrive_at = 16'($urandom);
                default:
                begin
                    near = int'(clock_now) + int'($urandom_range(0, 12)) - 6;
                    if (near < 0)
                        near = 0;
                    if (near > int'(pjts_pkg::TIME_MAX))
                        near = int'(pjts_pkg::TIME_MAX);
                    w.arrive_at = 16'(near);
                end
            endcase
            case ($urandom_range(0, 9))
                0:          w.runtime = 16'd0;
                1:          w.runtime = pjts_pkg::TIME_MAX;
                2, 3, 4:    w.runtime = 16'($urandom_range(0, 7));
                default:    w.runtime = 16'($urandom);
            endcase
            case ($urandom_range(0, 9))
                0:          w.priority_req = 8'd0;
                1:          w.priority_req = 8'hFF;
                2, 3, 4, 5: w.priority_req = 8'($urandom_range(0, 3));
                default:    w.priority_req = 8'($urandom);
            endcase
        end
        else if (pick < 76)
            w.mode = pjts_pkg::MODE_DISPATCH;
        else
        begin
            w.mode = pjts_pkg::MODE_COMPLETE;
            // mostly aim at a running slot, otherwise any slot at all
            if (running_map != '0 && $urandom_range(0, 3) != 0)
            begin
                first = $urandom_range(0, pjts_pkg::TABLE_DEPTH - 1);
                found = 1'b0;
                for (int k = 0; k < pjts_pkg::TABLE_DEPTH; k++)
                begin
                    if (!found && running_map[(first + k) % pjts_pkg::TABLE_DEPTH])
                    begin
                        w.slot = 8'((first + k) % pjts_pkg::TABLE_DEPTH);
                        found  = 1'b1;
                    end
                end
            end
        end
        return w;
    endfunction

    // Hold the word until it is taken; return at the following falling edge.
    task automatic send_word(input pjts_pkg::in_t w);
        in_valid <= 1'b1;
        in_data  <= w;
        if (w.mode == pjts_pkg::MODE_INSERT)
            inserts_sent++;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
    endtask

    task automatic send_random(input int count);
        int burst_left;
        int gap;
        burst_left = $urandom_range(1, 16);
        for (int k = 0; k < count; k++)
        begin
            send_word(random_word());
            burst_left--;
            if (burst_left == 0)
            begin
                gap = $urandom_range(0, 12);
                if (gap != 0)
                begin
                    in_valid <= 1'b0;
                    repeat (gap) @(negedge clk);
                end
                burst_left = $urandom_range(1, 16);
            end
        end
    endtask

    // Drop valid and wait until every expected word has come back.
    task automatic drain();
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (pending_count != 0);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_policy(input logic [1:0] pol);
        cfg_we    <= 1'b1;
        cfg_wdata <= pol;
        @(negedge clk);
        cfg_we    <= 1'b0;
        @(negedge clk);
    endtask

    // receiver: segments of steady, random, sparse and mostly-on ready, plus one long hold-off
    initial
    begin
        int seg_kind;
        int seg_len;
        bit hold_done;
        hold_done = 1'b0;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_req && !hold_done)
            begin
                out_ready <= 1'b0;
                repeat (400) @(negedge clk);
                hold_done = 1'b1;
            end
            else
            begin
                seg_kind = $urandom_range(0, 3);
                seg_len  = $urandom_range(1, 40);
                repeat (seg_len)
                begin
                    case (seg_kind)
                        0:       out_ready <= 1'b1;
                        1:       out_ready <= 1'($urandom_range(0, 1));
                        2:       out_ready <= ($urandom_range(0, 3) == 0);
                        default: out_ready <= ($urandom_range(0, 7) != 0);
                    endcase
                    @(negedge clk);
                end
            end
        end
    end

    initial
    begin
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_wdata = pjts_pkg::POL_ARRIVAL;
        in_valid  = 1'b0;
        in_data   = '0;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        write_policy(pjts_pkg::POL_ARRIVAL);

        // directed: empty table, bad completions, extreme fields, ties, wide finish time
        send_word(job_word(pjts_pkg::MODE_DISPATCH, 16'h0, 16'h0, 16'h0, 8'h0, 8'h0));
        send_word(job_word(pjts_pkg::MODE_COMPLETE, 16'h0, 16'h0, 16'h0, 8'h0, 8'd0));
        send_word(job_word(pjts_pkg::MODE_COMPLETE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF,
                           8'd255));
        send_word(job_word(pjts_pkg::MODE_TICK, 16'h0, 16'h0, 16'h0, 8'h0, 8'h0));
        send_word(job_word(pjts_pkg::MODE_INSERT, 16'hFFFF, 16'd0, 16'hFFFF, 8'hFF, 8'hFF));
        send_word(job_word(pjts_pkg::MODE_INSERT, 16'h0000, 16'hFFFF, 16'd0, 8'h00, 8'h00));
        send_word(job_word(pjts_pkg::MODE_INSERT, 16'h1234, 16'd1, 16'd5, 8'd7, 8'h5A));
        send_word(job_word(pjts_pkg::MODE_INSERT, 16'h0002, 16'd0, 16'd5, 8'd7, 8'hA5));
        send_word(job_word(pjts_pkg::MODE_COMPLETE, 16'h0, 16'h0, 16'h0, 8'h0, 8'd0));
        send_word(job_word(pjts_pkg::MODE_DISPATCH, 16'h0, 16'h0, 16'h0, 8'h0, 8'h0));
        send_word(job_word(pjts_pkg::MODE_COMPLETE, 16'h0, 16'h0, 16'h0, 8'h0, 8'd0));
        send_word(job_word(pjts_pkg::MODE_COMPLETE, 16'h0, 16'h0, 16'h0, 8'h0, 8'd0));
        send_word(job_word(pjts_pkg::MODE_DISPATCH, 16'h0, 16'h0, 16'h0, 8'h0, 8'h0));
        send_word(job_word(pjts_pkg::MODE_DISPATCH, 16'h0, 16'h0, 16'h0, 8'h0, 8'h0));
        send_word(job_word(pjts_pkg::MODE_DISPATCH, 16'h0, 16'h0, 16'h0, 8'h0, 8'h0));
        send_word(job_word(pjts_pkg::MODE_COMPLETE, 16'h0, 16'h0, 16'h0, 8'h0, 8'd3));
        send_word(job_word(pjts_pkg::MODE_COMPLETE, 16'h0, 16'h0, 16'h0, 8'h0, 8'd2));
        send_word(job_word(pjts_pkg::MODE_COMPLETE, 16'h0, 16'h0, 16'h0, 8'h0, 8'd1));
        drain();

        // random phases, one per policy; the receiver holds off once in the first
        send_random(120);
        hold_req = 1'b1;
        send_random(210);
        drain();
        write_policy(pjts_pkg::POL_RUNTIME);
        send_random(330);
        drain();
        write_policy(pjts_pkg::POL_PRIORITY);
        send_random(330);
        drain();
        write_policy(pjts_pkg::POL_NONE);
        send_random(300);
        // make sure the table fills up
        while (inserts_sent < pjts_pkg::TABLE_DEPTH + 4)
            send_word(job_word(pjts_pkg::MODE_INSERT, 16'($urandom), 16'($urandom),
                               16'($urandom), 8'($urandom), 8'($urandom)));
        drain();

        write_policy(2'($urandom_range(0, 3)));
        send_random(120);
        drain();
        write_policy(pjts_pkg::POL_ARRIVAL);
        send_random(120);
        drain();

        repeat (300) @(negedge clk);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        #(60_000_000);
        $display("TB_ERROR");
        $finish;
    end

endmodule

/* filelist.f */
rtl/core/pjts_pkg.sv
rtl/core/pjts_table.sv
rtl/core/policy_job_table_selector.sv
rtl/core/pjts_checker.sv
verif/pjts_checker.sv
verif/policy_job_table_selector_tb.sv
